// File: rtl/led_key_controller_command_interface_assert.svh
// Assertion macros shared by the LED and key controller command interface RTL.
`ifndef LED_KEY_CONTROLLER_COMMAND_INTERFACE_ASSERT_SVH
`define LED_KEY_CONTROLLER_COMMAND_INTERFACE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check that a condition implies another in the same cycle.
`define LKC_ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("lkc assertion failed");

// Check that a condition implies another in the next cycle.
`define LKC_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("lkc assertion failed");

`else

`define LKC_ASSERT_IMPLY(label, clk, rst, cond, prop)
`define LKC_ASSERT_NEXT(label, clk, rst, cond, prop)

`endif

`endif

// File: rtl/lkc_pkg.sv
// Types and constants of the LED and key controller command interface.
`default_nettype none

package lkc_pkg;

   // Top two bits of a command byte.
   localparam logic [1:0] CMD_UNDEFINED    = 2'b00;
   localparam logic [1:0] CMD_DATA_MODE    = 2'b01;
   localparam logic [1:0] CMD_DISPLAY_CTRL = 2'b10;
   localparam logic [1:0] CMD_ADDRESS      = 2'b11;

   localparam int RAM_ADDR_W = 4;

   typedef struct packed {
      logic        command;
      logic        first_of_frame;
      logic [7:0]  data_byte;
      logic [31:0] key_data;
   } req_type;

   typedef struct packed {
      logic [7:0]            read_data;
      logic                  ram_write;
      logic [RAM_ADDR_W-1:0] ram_addr;
      logic [7:0]            ram_data;
      logic                  display_on;
      logic [2:0]            brightness;
      logic                  status;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_KEY_READ,
      OP_DATA_MODE,
      OP_DISPLAY_CTRL,
      OP_ADDRESS_SET,
      OP_RAM_WRITE,
      OP_UNDEFINED
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  data_byte;
      logic [31:0] key_data;
   } entry_type;

endpackage

`default_nettype wire

// File: rtl/lkc_front.sv
// Front end: take request transfers and classify each byte into an operation.
`default_nettype none

module lkc_front
   import lkc_pkg::*;
(
   input  wire logic      req_valid,
   input  wire req_type   req_payload,
   output logic           req_stall,
   input  wire logic      queue_full,
   output logic           push,
   output entry_type      entry
);

   op_type op;

   always_comb begin
      if (req_payload.command) begin
         op = OP_KEY_READ;
      end else if (req_payload.first_of_frame) begin
         case (req_payload.data_byte[7:6])
            CMD_DATA_MODE:    op = OP_DATA_MODE;
            CMD_DISPLAY_CTRL: op = OP_DISPLAY_CTRL;
            CMD_ADDRESS:      op = OP_ADDRESS_SET;
            default:          op = OP_UNDEFINED;
         endcase
      end else begin
         op = OP_RAM_WRITE;
      end
   end

   // Hold the host off while the queue has no free slot.
   assign req_stall       = queue_full;
   assign push            = req_valid && !queue_full;
   assign entry.op        = op;
   assign entry.data_byte = req_payload.data_byte;
   assign entry.key_data  = req_payload.key_data;

endmodule

`default_nettype wire

// File: rtl/lkc_queue.sv
// Short FIFO between the classifying front end and the executing back end.
`default_nettype none
`include "led_key_controller_command_interface_assert.svh"

module lkc_queue
   import lkc_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type push_entry,
   input  wire logic      pop,
   output logic           full,
   output logic           not_empty,
   output entry_type      head
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      next_ptr = (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `LKC_ASSERT_IMPLY(a_no_push_when_full, clock, reset, push, !full)
   `LKC_ASSERT_IMPLY(a_no_pop_when_empty, clock, reset, pop, not_empty)
   `LKC_ASSERT_NEXT(a_push_fills, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1)

endmodule

`default_nettype wire

// File: rtl/lkc_back.sv
// Back end: carry out queued operations on the controller state, register results.
`default_nettype none
`include "led_key_controller_command_interface_assert.svh"

module lkc_back
   import lkc_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      entry_valid,
   input  wire entry_type entry,
   output logic           pop,
   output logic           rsp_valid,
   input  wire logic      rsp_stall,
   output rsp_type        rsp_payload
);

   logic [RAM_ADDR_W-1:0] ptr_ff, ptr_in;
   logic                  fixed_ff, fixed_in;
   logic                  key_mode_ff, key_mode_in;
   logic                  disp_en_ff, disp_en_in;
   logic [2:0]            bright_ff, bright_in;
   logic [1:0]            key_idx_ff, key_idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   // Advance when the output register is empty or being drained this cycle.
   assign pop          = entry_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = pop || (rsp_valid_ff && rsp_stall);

   always_comb begin
      ptr_in      = ptr_ff;
      fixed_in    = fixed_ff;
      key_mode_in = key_mode_ff;
      disp_en_in  = disp_en_ff;
      bright_in   = bright_ff;
      key_idx_in  = key_idx_ff;

      rsp_in.read_data = '0;
      rsp_in.ram_write = 1'b0;
      rsp_in.ram_data  = '0;
      rsp_in.status    = 1'b0;

      case (entry.op)
         OP_KEY_READ: begin
            if (key_mode_ff) begin
               rsp_in.read_data = 8'(entry.key_data >> {key_idx_ff, 3'b000});
               key_idx_in       = key_idx_ff + 1'b1;
            end else begin
               rsp_in.status = 1'b1;
            end
         end
         OP_DATA_MODE: begin
            key_mode_in = entry.data_byte[1];
            fixed_in    = entry.data_byte[2];
            key_idx_in  = '0;
         end
         OP_DISPLAY_CTRL: begin
            disp_en_in = entry.data_byte[3];
            bright_in  = entry.data_byte[2:0];
         end
         OP_ADDRESS_SET: begin
            ptr_in = entry.data_byte[RAM_ADDR_W-1:0];
         end
         OP_RAM_WRITE: begin
            if (key_mode_ff) begin
               rsp_in.status = 1'b1;
            end else begin
               rsp_in.ram_write = 1'b1;
               rsp_in.ram_data  = entry.data_byte;
               if (!fixed_ff) begin
                  ptr_in = ptr_ff + 1'b1;
               end
            end
         end
         default: begin
            rsp_in.status = 1'b1;
         end
      endcase

      // A write reports its own address, anything else the pointer after the step.
      rsp_in.ram_addr   = rsp_in.ram_write ? ptr_ff : ptr_in;
      rsp_in.display_on = disp_en_in;
      rsp_in.brightness = bright_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff       <= '0;
         fixed_ff     <= 1'b0;
         key_mode_ff  <= 1'b0;
         disp_en_ff   <= 1'b0;
         bright_ff    <= '0;
         key_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            ptr_ff      <= ptr_in;
            fixed_ff    <= fixed_in;
            key_mode_ff <= key_mode_in;
            disp_en_ff  <= disp_en_in;
            bright_ff   <= bright_in;
            key_idx_ff  <= key_idx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `LKC_ASSERT_IMPLY(a_no_pop_while_stalled, clock, reset, rsp_valid_ff && rsp_stall, !pop)
   `LKC_ASSERT_IMPLY(a_write_is_accepted, clock, reset, rsp_valid_ff && rsp_ff.ram_write, !rsp_ff.status && rsp_ff.read_data == '0)
   `LKC_ASSERT_NEXT(a_data_mode_restarts_keys, clock, reset, pop && entry.op == OP_DATA_MODE, key_idx_ff == '0)

endmodule

`default_nettype wire

// File: rtl/led_key_controller_command_interface.sv
// Top level of the LED and key controller command interface.
//
// Device side of a strobe-framed byte link to an LED and key controller.
// Request channel (req_valid / req_stall / req_payload): one transfer per
// byte the host writes or reads, flagged with command and first_of_frame,
// plus the key matrix sample for reads.
// Response channel (rsp_valid / rsp_stall / rsp_payload): exactly one
// transfer per request, in order, carrying the key byte read, the display
// RAM write (address and data), the current display enable and brightness,
// and an accepted/ignored status.
// Order: a request taken is first written into the queue, then popped and
// registered in the response register, so its response is valid from then
// on and holds there until it transfers.
// Throughput: one transfer per cycle unless a side stalls; the back end
// updates all controller state per popped byte; nothing loops across items.
// A front end classifies each byte and pushes it into a small queue of
// QUEUE_DEPTH entries; the back end pops, executes and loads the response
// register. When the receiver stalls, the response register holds, the
// queue fills, and req_stall rises once the queue is full.
// Reset (synchronous, active high) clears the pointer, modes, display
// enable, brightness, key byte index and empties the queue. Display RAM
// contents leave the block only as write transfers on the response channel.
`default_nettype none

module led_key_controller_command_interface
   import lkc_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_payload
);

   logic      push;
   logic      pop;
   logic      queue_full;
   logic      queue_not_empty;
   entry_type push_entry;
   entry_type head_entry;

   // Classify incoming bytes; stall the host only when the queue is full.
   lkc_front u_front (
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .req_stall   (req_stall),
      .queue_full  (queue_full),
      .push        (push),
      .entry       (push_entry)
   );

   // Decouple the two halves so each can stall on its own.
   lkc_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .not_empty  (queue_not_empty),
      .head       (head_entry)
   );

   // Execute operations and hold the response until it is transferred.
   lkc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .entry_valid (queue_not_empty),
      .entry       (head_entry),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire
